### hdl/flim_pkg.sv
// Package for the flow id map with aging: transfer payload types, kind and
// status codes, and the token that travels down the row of table cells.
// No dependencies.
`default_nettype none

package flim_pkg;

  localparam int SRC_KEY_BITS = 48;
  localparam int ID_BITS      = 32;
  localparam int CNT_BITS     = 7;
  // widest key and slot index the cells support
  localparam int TOK_KEY_BITS = 64;
  localparam int TOK_IDX_BITS = 10;

  localparam logic [1:0] KIND_LOCAL  = 2'd0;
  localparam logic [1:0] KIND_REMOTE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [2:0] ST_TO_REMOTE = 3'd0;
  localparam logic [2:0] ST_TO_LOCAL  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TICK      = 3'd4;

  localparam logic [CNT_BITS-1:0] COUNT_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SRC_KEY_BITS-1:0] src_key;
    logic [ID_BITS-1:0]      stream_id;
    logic [ID_BITS-1:0]      new_id;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [ID_BITS-1:0]      out_id;
    logic [SRC_KEY_BITS-1:0] out_key;
    logic [CNT_BITS-1:0]     expired_count;
  } rsp_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic [1:0]              kind;
    logic [TOK_KEY_BITS-1:0] key;      // lookup key, or key found
    logic [ID_BITS-1:0]      sid;      // lookup id, or id found
    logic                    hit;
    logic                    free_ok;
    logic [TOK_IDX_BITS-1:0] free_idx; // lowest free slot seen so far
    logic [CNT_BITS-1:0]     count;    // entries freed by a tick
  } tok_t;

endpackage

`default_nettype wire

### hdl/flim_cell.sv
// One table slot of the flow id map: holds key, id, valid and activity flags,
// and updates the token it passes to the next slot. Depends on flim_pkg.
`default_nettype none

module flim_cell
  import flim_pkg::*;
#(
  parameter int KEY_BITS = 48,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  tok_t                tin,
  output tok_t                tout,
  input  logic                ins,
  input  logic [KEY_BITS-1:0] ins_key,
  input  logic [ID_BITS-1:0]  ins_id
);

  logic                valid;
  logic                fwd;
  logic                rev;
  logic [KEY_BITS-1:0] key;
  logic [ID_BITS-1:0]  id;

  logic valid_next;
  logic fwd_next;
  logic rev_next;
  tok_t tout_next;
  logic match_key;
  logic match_id;

  assign match_key = valid && (key == tin.key[KEY_BITS-1:0]);
  assign match_id  = valid && (id == tin.sid);

  // act on the token passing through this slot
  always_comb begin
    valid_next = valid;
    fwd_next   = fwd;
    rev_next   = rev;
    tout_next  = tin;
    if (tin.valid) begin
      unique case (tin.kind)
        KIND_LOCAL: begin
          if (!tin.hit && match_key) begin
            fwd_next      = 1'b1;
            tout_next.hit = 1'b1;
            tout_next.sid = id;
          end
          if (!valid && !tin.free_ok) begin
            tout_next.free_ok  = 1'b1;
            tout_next.free_idx = TOK_IDX_BITS'(IDX);
          end
        end
        KIND_REMOTE: begin
          if (!tin.hit && match_id) begin
            rev_next      = 1'b1;
            tout_next.hit = 1'b1;
            tout_next.key = TOK_KEY_BITS'(key);
          end
        end
        KIND_TICK: begin
          if (valid) begin
            if (fwd || rev) begin
              fwd_next = 1'b0;
              rev_next = 1'b0;
            end else begin
              valid_next = 1'b0;
              if (tin.count != COUNT_MAX) begin
                tout_next.count = tin.count + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hold slot state; an insert from the top level overrides
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      fwd        <= 1'b0;
      rev        <= 1'b0;
      tout.valid <= 1'b0;
    end else begin
      tout <= tout_next;
      if (ins) begin
        valid <= 1'b1;
        fwd   <= 1'b1;
        rev   <= 1'b0;
      end else begin
        valid <= valid_next;
        fwd   <= fwd_next;
        rev   <= rev_next;
      end
    end
  end

  // payload of the slot
  always_ff @(posedge clk) begin
    if (ins) begin
      key <= ins_key;
      id  <= ins_id;
    end
  end

endmodule

`default_nettype wire

### hdl/flow_id_map_with_aging_top.sv
// Top level of the flow id map with aging: row of table cells, token
// injection, insert on miss and result transfer. Depends on flim_pkg, flim_cell.
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | req_t (kind, key, ids)
//   rsp      | out       | rsp_valid/rsp_stall  | rsp_t (status, id, key, count)
//
// One item at a time: a token walks the row of ENTRIES cells, one cell per
// cycle; its result is then registered in res and moved on to rsp.
// A local miss is inserted into the lowest free slot as the token leaves.
// Reset (rst, synchronous) clears all valid and activity flags at once.
// A stalled result holds in the output register; the next item is taken
// while it waits, and its own result holds until the register frees.
`default_nettype none

module flow_id_map_with_aging_top
  import flim_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]         state;
  logic [ID_BITS-1:0] new_id;
  rsp_t               res;

  tok_t               inj;
  tok_t               tok [ENTRIES];
  tok_t               tex;
  logic               accept;
  logic               ins_en;
  logic [ENTRIES-1:0] ins_sel;
  rsp_t               res_next;

  assign req_stall = rst || (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign tex       = tok[ENTRIES-1];

  // build the token for a new item
  always_comb begin
    inj          = '0;
    inj.valid    = accept;
    inj.kind     = req.kind;
    inj.key      = TOK_KEY_BITS'(req.src_key);
    inj.sid      = req.stream_id;
  end

  // row of table cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tok_t tin;
    if (i == 0) begin : g_first
      assign tin = inj;
    end else begin : g_next
      assign tin = tok[i-1];
    end
    assign ins_sel[i] = ins_en && (tex.free_idx == TOK_IDX_BITS'(i));
    flim_cell #(
      .KEY_BITS(KEY_BITS),
      .IDX     (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tin    (tin),
      .tout   (tok[i]),
      .ins    (ins_sel[i]),
      .ins_key(tex.key[KEY_BITS-1:0]),
      .ins_id (new_id)
    );
  end

  // form the result as the token leaves the row
  always_comb begin
    res_next = '0;
    ins_en   = 1'b0;
    case (tex.kind)
      KIND_LOCAL: begin
        if (tex.hit) begin
          res_next.status = ST_TO_REMOTE;
          res_next.out_id = tex.sid;
        end else if (tex.free_ok) begin
          ins_en          = tex.valid;
          res_next.status = ST_TO_REMOTE;
          res_next.out_id = new_id;
        end else begin
          res_next.status = ST_FULL;
        end
      end
      KIND_REMOTE: begin
        if (tex.hit) begin
          res_next.status  = ST_TO_LOCAL;
          res_next.out_key = tex.key[SRC_KEY_BITS-1:0];
        end else begin
          res_next.status = ST_UNKNOWN;
        end
      end
      default: begin
        res_next.status        = ST_TICK;
        res_next.expired_count = tex.count;
      end
    endcase
  end

  // sequence one item and move its result to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_HOLD && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tex.valid) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // capture payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      new_id <= req.new_id;
    end
    if (state == S_RUN && tex.valid) begin
      res <= res_next;
    end
    if (state == S_HOLD && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire
